// ===== src/cft_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cft_pkg
// Shared types, codes and helpers of the CSV field tokenizer.
// ---------------------------------------------------------------------------
package cft_pkg;

  // Default maximum length of a held whitespace run
  localparam int DEFAULT_MAX_WS_RUN = 16;

  // Character codes
  localparam logic [7:0] QUOTE_CHAR = 8'd34;
  localparam logic [7:0] SEP_RESET  = 8'd59;

  // Request types
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_INVALID   = 2'd2;
  localparam logic [1:0] KIND_LINE_END  = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_FINAL
  } ctrl_state_t;

  // Source of the output register load
  typedef enum logic [1:0] {
    OSEL_FIN,
    OSEL_WS,
    OSEL_FE
  } out_sel_t;

  // Controller -> datapath
  typedef struct packed {
    logic     use_hold;
    logic     hold_load;
    logic     commit;
    logic     rd_first;
    logic     rd_next;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cft_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic flush_needed;
    logic pre_fe;
    logic fin_valid;
    logic flush_last;
    logic out_free;
  } cft_status_t;

  // Whitespace: tab, LF, VT, FF, CR and space
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

// ===== src/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a text line into fields, one character request at a time.
// ---------------------------------------------------------------------------
// A request carries one character or an end of line. Most requests give at
// most one result and are taken one per cycle while the output register is
// free; a single output register lies between the two sides. A character
// other than whitespace and the separator that follows a held whitespace run
// inside a started field replays the run first: such a request starts the
// store read, gives one result per held byte and then its own result, if it
// has one, as the whitespace store has a single registered read port. An end
// of line that closes a started field gives two results (field end, then line
// end). An output stall holds each step.
// The separator register may be written only while no request is in flight.
// ---------------------------------------------------------------------------
module csv_field_tokenizer
  import cft_pkg::*;
#(
  parameter int MAX_WHITESPACE_RUN = DEFAULT_MAX_WS_RUN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] ch_res,
  output logic       last
);

  cft_cmd_t    cmd;
  cft_status_t status;

  // Sequencer
  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Line state, whitespace store and output register
  cft_datapath #(
    .MAX_WHITESPACE_RUN (MAX_WHITESPACE_RUN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .ch_res    (ch_res),
    .last      (last),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== src/cft_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cft_ctrl
// Sequencer of the tokenizer: single-result requests, whitespace flush,
// and the trailing result after a flush or a field end.
// ---------------------------------------------------------------------------
module cft_ctrl
  import cft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cft_status_t status,
  output cft_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.out_free) begin
          if (status.flush_needed) begin
            state_next = ST_FLUSH;
          end else if (status.pre_fe) begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free && status.flush_last) begin
          state_next = status.fin_valid ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.out_sel = OSEL_FIN;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          if (status.flush_needed) begin
            cmd.hold_load = 1'b1;
            cmd.rd_first  = 1'b1;
          end else if (status.pre_fe) begin
            cmd.hold_load = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_sel   = OSEL_FE;
            cmd.out_last  = 1'b0;
          end else begin
            cmd.commit   = 1'b1;
            cmd.out_load = status.fin_valid;
            cmd.out_sel  = OSEL_FIN;
            cmd.out_last = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        cmd.use_hold = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_WS;
          cmd.out_last = status.flush_last && !status.fin_valid;
          cmd.rd_next  = !status.flush_last;
          cmd.commit   = status.flush_last && !status.fin_valid;
        end
      end
      ST_FINAL: begin
        cmd.use_hold = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_FIN;
          cmd.out_last = 1'b1;
          cmd.commit   = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The trailing result always exists when sequenced
  a_final_has_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> status.fin_valid)
    else $error("final state without a final result");

  // Flags stay put for the whole flush
  a_flush_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> status.flush_needed)
    else $error("flush state without a pending flush");

endmodule

// ===== src/cft_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cft_datapath
// Line state, separator register, whitespace store, request decode and
// output register of the tokenizer.
// ---------------------------------------------------------------------------
module cft_datapath
  import cft_pkg::*;
#(
  parameter int MAX_WHITESPACE_RUN = DEFAULT_MAX_WS_RUN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        req_type,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  ch_res,
  output logic        last,
  input  cft_cmd_t    cmd,
  output cft_status_t status
);

  localparam int CW = $clog2(MAX_WHITESPACE_RUN + 1);
  localparam int IW = (MAX_WHITESPACE_RUN > 1) ? $clog2(MAX_WHITESPACE_RUN) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WHITESPACE_RUN);

  logic [7:0]    separator;
  logic          hold_type;
  logic [7:0]    hold_ch;
  logic          in_quotes, quote_odd, field_started, line_dropped;
  logic          in_quotes_next, quote_odd_next, field_started_next, line_dropped_next;
  logic [CW-1:0] pending_count, pending_count_next;
  logic [7:0]    pend_mem [MAX_WHITESPACE_RUN];
  logic [7:0]    rd_data;
  logic [IW-1:0] fidx;

  logic          src_type;
  logic [7:0]    src_ch;
  logic          ws_wr;
  logic          flush_needed, pre_fe, fin_valid;
  logic [1:0]    fin_kind;
  logic [7:0]    fin_ch;
  logic          out_free;

  // Separator register
  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEP_RESET;
    end else if (cfg_we) begin
      separator <= cfg_data;
    end
  end

  // Request hold for multi-result requests
  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_type <= req_type;
      hold_ch   <= ch;
    end
  end

  assign src_type = cmd.use_hold ? hold_type : req_type;
  assign src_ch   = cmd.use_hold ? hold_ch : ch;

  // Request decode against the current line state
  always_comb begin
    logic sep_hit;
    logic qo_t;
    in_quotes_next     = in_quotes;
    quote_odd_next     = quote_odd;
    field_started_next = field_started;
    line_dropped_next  = line_dropped;
    pending_count_next = pending_count;
    ws_wr        = 1'b0;
    flush_needed = 1'b0;
    pre_fe       = 1'b0;
    fin_valid    = 1'b0;
    fin_kind     = KIND_CHAR;
    fin_ch       = 8'd0;
    sep_hit      = (src_ch == separator) && (!in_quotes || !quote_odd);
    qo_t         = in_quotes ? !quote_odd : quote_odd;
    if (src_type == REQ_EOL) begin
      pre_fe             = !line_dropped && field_started;
      fin_valid          = 1'b1;
      fin_kind           = KIND_LINE_END;
      in_quotes_next     = 1'b0;
      quote_odd_next     = 1'b0;
      field_started_next = 1'b0;
      line_dropped_next  = 1'b0;
      pending_count_next = '0;
    end else if (!line_dropped) begin
      if (is_ws(src_ch)) begin
        if (pending_count < MAX_CNT) begin
          ws_wr              = 1'b1;
          pending_count_next = pending_count + CW'(1);
        end
      end else begin
        pending_count_next = '0;
        flush_needed = (pending_count != '0) && field_started && !sep_hit;
        if (sep_hit) begin
          fin_valid          = 1'b1;
          fin_kind           = KIND_FIELD_END;
          in_quotes_next     = 1'b0;
          quote_odd_next     = 1'b0;
          field_started_next = 1'b0;
        end else if (src_ch == QUOTE_CHAR) begin
          if (!field_started && !in_quotes) begin
            // opening quote
            in_quotes_next = 1'b1;
            quote_odd_next = 1'b1;
          end else begin
            quote_odd_next = qo_t;
            if (!in_quotes || qo_t) begin
              fin_valid          = 1'b1;
              fin_ch             = src_ch;
              field_started_next = 1'b1;
            end
          end
        end else if (in_quotes && !quote_odd) begin
          // plain character after a closed quote
          fin_valid         = 1'b1;
          fin_kind          = KIND_INVALID;
          line_dropped_next = 1'b1;
        end else begin
          fin_valid          = 1'b1;
          fin_ch             = src_ch;
          field_started_next = 1'b1;
        end
      end
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_odd     <= 1'b0;
      field_started <= 1'b0;
      line_dropped  <= 1'b0;
      pending_count <= '0;
    end else if (cmd.commit) begin
      in_quotes     <= in_quotes_next;
      quote_odd     <= quote_odd_next;
      field_started <= field_started_next;
      line_dropped  <= line_dropped_next;
      pending_count <= pending_count_next;
    end
  end

  // Whitespace store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && ws_wr) begin
      pend_mem[pending_count[IW-1:0]] <= src_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      rd_data <= pend_mem[0];
    end else if (cmd.rd_next) begin
      rd_data <= pend_mem[fidx + IW'(1)];
    end
  end

  // Flush index
  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      fidx <= '0;
    end else if (cmd.rd_next) begin
      fidx <= fidx + IW'(1);
    end
  end

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_WS: begin
          kind   <= KIND_CHAR;
          ch_res <= rd_data;
        end
        OSEL_FE: begin
          kind   <= KIND_FIELD_END;
          ch_res <= 8'd0;
        end
        default: begin
          kind   <= fin_kind;
          ch_res <= fin_ch;
        end
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    status.flush_needed = flush_needed;
    status.pre_fe       = pre_fe;
    status.fin_valid    = fin_valid;
    status.flush_last   = ((CW'(fidx) + CW'(1)) == pending_count);
    status.out_free     = out_free;
  end

  // A flush starts only with whitespace held inside a started field
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_first |-> (pending_count != '0) && field_started)
    else $error("flush started with nothing to flush");

  // Held run never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= MAX_CNT)
    else $error("whitespace count beyond store depth");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output register loaded while a result waits");

endmodule
